>>> hw/rtl/sqvs_pkg.sv
// Shared types, constants and table functions for the sprite quad vertex setup.
`default_nettype none

package sqvs_pkg;

  localparam int SINE_ENTRIES_DEF = 1024;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_VIEWPORT_W = 2'd0;
  localparam logic [1:0] REG_VIEWPORT_H = 2'd1;
  localparam logic [1:0] REG_TEXTURE_W  = 2'd2;
  localparam logic [1:0] REG_TEXTURE_H  = 2'd3;

  localparam int CFG_W     = 14;
  localparam int NUM_W     = 35;
  localparam int DEN_W     = 19;
  localparam int QUO_W     = 16;
  localparam int ANGLE_MOD = 5760;

  // floor(x / 45) = (x * RECIP45) >> RECIP45_SHIFT for any x below 2^19.
  localparam logic [19:0] RECIP45       = 20'd745655;
  localparam int          RECIP45_SHIFT = 25;

  typedef struct packed {
    logic signed [15:0] dst_left;
    logic signed [15:0] dst_top;
    logic signed [15:0] dst_width;
    logic signed [15:0] dst_height;
    logic [31:0]        tint_rgba;
    logic [12:0]        rot_angle;
    logic [15:0]        src_left;
    logic [15:0]        src_top;
    logic [15:0]        src_width;
    logic [15:0]        src_height;
  } sprite_t;

  typedef struct packed {
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic [31:0]        vertex_rgba;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_vertex;
  } vertex_t;

  // Sine of a turn phase in Q32, result in Q14. Evaluated only while the
  // lookup tables are built.
  function automatic logic signed [15:0] isin(input logic [31:0] p);
    logic [1:0]         q;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] s;
    q = p[31:30];
    r = {34'd0, p[29:0]};
    if (q[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    s    = signed'(x);
    term = ((x * x2) >> 30) / 64'd6;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    s    = s + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    s    = s + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    s    = s - signed'(term);
    if (s < 0) begin
      s = 0;
    end
    s = (s + 64'sd32768) >>> 16;
    return q[1] ? 16'(-s) : 16'(s);
  endfunction

  // Corner sent as the k-th vertex: triangles 0,1,2 and 2,1,3.
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd1;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sprite_quad_vertex_setup.sv
// Top level: rotated sprite quad setup, six vertices per sprite request.
// The first vertex reaches the result ports through the stage registers and the divider;
// the other five follow without gaps.
// A new sprite is accepted while busy is low, before the last one is through, so requests
// overlap; busy rises after each accepted request to space them for the six-vertex output.
// Synchronous active-high reset clears valid bits and the busy counter;
// configuration registers return to 1280, 720, 256 and 256.
`default_nettype none

module sprite_quad_vertex_setup #(
  parameter int SINE_TABLE_ENTRIES = sqvs_pkg::SINE_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire sqvs_pkg::sprite_t sprite,
  output logic                   vertex_valid,
  output sqvs_pkg::vertex_t      vertex,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
  localparam int DIV_STAGES = sqvs_pkg::QUO_W;
  localparam int LANES = 12;

  typedef logic [SINE_TABLE_ENTRIES-1:0][15:0] rom_t;

  function automatic rom_t build_rom(input logic cos_sel);
    rom_t        rom;
    logic [63:0] ph;
    for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      ph = (64'(i) << 32) / SINE_TABLE_ENTRIES;
      if (cos_sel) begin
        ph = ph + 64'h4000_0000;
      end
      rom[i] = sqvs_pkg::isin(ph[31:0]);
    end
    return rom;
  endfunction

  localparam rom_t SIN_ROM = build_rom(1'b0);
  localparam rom_t COS_ROM = build_rom(1'b1);

  // Negative numerators give quotient 0; those at or past den * 2^16 give all ones.
  function automatic logic [sqvs_pkg::NUM_W-1:0] clamp_num(
    input logic signed [37:0]         n,
    input logic [sqvs_pkg::DEN_W-1:0] den
  );
    logic [37:0] lim;
    lim = {3'd0, den, 16'd0};
    if (n < 0) begin
      return '0;
    end else if (38'(n) >= lim) begin
      return sqvs_pkg::NUM_W'(lim - 38'd1);
    end else begin
      return sqvs_pkg::NUM_W'(n);
    end
  endfunction

  // ---------------- configuration ----------------
  logic [13:0] viewport_w, viewport_h, texture_w, texture_h;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_w <= 14'd1280;
      viewport_h <= 14'd720;
      texture_w  <= 14'd256;
      texture_h  <= 14'd256;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        sqvs_pkg::REG_VIEWPORT_W: viewport_w <= pwdata[13:0];
        sqvs_pkg::REG_VIEWPORT_H: viewport_h <= pwdata[13:0];
        sqvs_pkg::REG_TEXTURE_W:  texture_w  <= pwdata[13:0];
        sqvs_pkg::REG_TEXTURE_H:  texture_h  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sqvs_pkg::REG_VIEWPORT_W: prdata = {18'd0, viewport_w};
      sqvs_pkg::REG_VIEWPORT_H: prdata = {18'd0, viewport_h};
      sqvs_pkg::REG_TEXTURE_W:  prdata = {18'd0, texture_w};
      sqvs_pkg::REG_TEXTURE_H:  prdata = {18'd0, texture_h};
      default:                  prdata = '0;
    endcase
  end

  // A register holding zero acts as one. Viewport divisors are 32 times the scale, texture divisors twice it.
  logic [13:0]                 vw_nz, vh_nz, tw_nz, th_nz;
  logic [sqvs_pkg::DEN_W-1:0] den_x, den_y, den_u, den_v;

  assign vw_nz = (viewport_w == 14'd0) ? 14'd1 : viewport_w;
  assign vh_nz = (viewport_h == 14'd0) ? 14'd1 : viewport_h;
  assign tw_nz = (texture_w == 14'd0) ? 14'd1 : texture_w;
  assign th_nz = (texture_h == 14'd0) ? 14'd1 : texture_h;
  assign den_x = {vw_nz, 5'd0};
  assign den_y = {vh_nz, 5'd0};
  assign den_u = {4'd0, tw_nz, 1'b0};
  assign den_v = {4'd0, th_nz, 1'b0};

  // ---------------- request accept ----------------
  logic [2:0] busy_cnt;
  logic       accept;

  assign busy   = busy_cnt != 3'd0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= 3'd0;
    end else if (accept) begin
      busy_cnt <= 3'd5;
    end else if (busy_cnt != 3'd0) begin
      busy_cnt <= busy_cnt - 3'd1;
    end
  end

  // ---------------- stage 1: angle reduction and scaling ----------------
  logic [12:0] ang_red;
  logic [25:0] ang_scaled;

  assign ang_red = (sprite.rot_angle >= 13'(sqvs_pkg::ANGLE_MOD))
                 ? sprite.rot_angle - 13'(sqvs_pkg::ANGLE_MOD) : sprite.rot_angle;
  assign ang_scaled = 26'(ang_red) * 26'(SINE_TABLE_ENTRIES);

  logic               v1;
  logic signed [15:0] s1_dl, s1_dt, s1_dw, s1_dh;
  logic [31:0]        s1_rgba;
  logic [15:0]        s1_sl, s1_st, s1_sw, s1_sh;
  logic [18:0]        s1_x7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    s1_dl   <= sprite.dst_left;
    s1_dt   <= sprite.dst_top;
    s1_dw   <= sprite.dst_width;
    s1_dh   <= sprite.dst_height;
    s1_rgba <= sprite.tint_rgba;
    s1_sl   <= sprite.src_left;
    s1_st   <= sprite.src_top;
    s1_sw   <= sprite.src_width;
    s1_sh   <= sprite.src_height;
    s1_x7   <= ang_scaled[25:7];
  end

  // ---------------- stage 2: table index, centre, texture numerators ----------------
  logic [38:0] idx_prod;
  logic [16:0] sum_u, sum_v;

  assign idx_prod = 39'(s1_x7) * 39'(sqvs_pkg::RECIP45);
  assign sum_u    = 17'(s1_sl) + 17'(s1_sw);
  assign sum_v    = 17'(s1_st) + 17'(s1_sh);

  logic               v2;
  logic [IDX_W-1:0]   s2_idx;
  logic signed [15:0] s2_dw, s2_dh;
  logic signed [17:0] s2_cx, s2_cy;
  logic [31:0]        s2_rgba;
  logic [28:0]        s2_tn [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_idx   <= idx_prod[sqvs_pkg::RECIP45_SHIFT +: IDX_W];
    s2_dw    <= s1_dw;
    s2_dh    <= s1_dh;
    s2_cx    <= {s1_dl[15], s1_dl, 1'b0} + {{2{s1_dw[15]}}, s1_dw};
    s2_cy    <= {s1_dt[15], s1_dt, 1'b0} + {{2{s1_dh[15]}}, s1_dh};
    s2_rgba  <= s1_rgba;
    s2_tn[0] <= 29'({s1_sl, 11'd0}) + 29'(tw_nz);
    s2_tn[1] <= 29'({sum_u, 11'd0}) + 29'(tw_nz);
    s2_tn[2] <= 29'({s1_st, 11'd0}) + 29'(th_nz);
    s2_tn[3] <= 29'({sum_v, 11'd0}) + 29'(th_nz);
  end

  // ---------------- stage 3: sine and cosine lookup, texture clamp ----------------
  logic                       v3;
  logic signed [15:0]         s3_sn, s3_cs, s3_dw, s3_dh;
  logic signed [17:0]         s3_cx, s3_cy;
  logic [31:0]                s3_rgba;
  logic [sqvs_pkg::NUM_W-1:0] s3_tn [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_sn    <= SIN_ROM[s2_idx];
    s3_cs    <= COS_ROM[s2_idx];
    s3_dw    <= s2_dw;
    s3_dh    <= s2_dh;
    s3_cx    <= s2_cx;
    s3_cy    <= s2_cy;
    s3_rgba  <= s2_rgba;
    s3_tn[0] <= clamp_num(38'(s2_tn[0]), den_u);
    s3_tn[1] <= clamp_num(38'(s2_tn[1]), den_u);
    s3_tn[2] <= clamp_num(38'(s2_tn[2]), den_v);
    s3_tn[3] <= clamp_num(38'(s2_tn[3]), den_v);
  end

  // ---------------- stage 4: rotation products ----------------
  logic                       v4;
  logic signed [31:0]         s4_pcw, s4_psh, s4_psw, s4_pch;
  logic signed [17:0]         s4_cx, s4_cy;
  logic [31:0]                s4_rgba;
  logic [sqvs_pkg::NUM_W-1:0] s4_tn [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    s4_pcw  <= s3_cs * s3_dw;
    s4_psh  <= s3_sn * s3_dh;
    s4_psw  <= s3_sn * s3_dw;
    s4_pch  <= s3_cs * s3_dh;
    s4_cx   <= s3_cx;
    s4_cy   <= s3_cy;
    s4_rgba <= s3_rgba;
    s4_tn   <= s3_tn;
  end

  // ---------------- stage 5: rotated corners in 2^-19 pixel ----------------
  logic signed [34:0] x_sum [4];
  logic signed [34:0] y_sum [4];

  always_comb begin
    logic signed [34:0] cxs, cys, pcw, psh, psw, pch;
    cxs = {{3{s4_cx[17]}}, s4_cx, 14'd0};
    cys = {{3{s4_cy[17]}}, s4_cy, 14'd0};
    pcw = 35'(s4_pcw);
    psh = 35'(s4_psh);
    psw = 35'(s4_psw);
    pch = 35'(s4_pch);
    for (int c = 0; c < 4; c++) begin
      x_sum[c] = cxs + (c[0] ? pcw : -pcw) - (c[1] ? psh : -psh);
      y_sum[c] = cys + (c[0] ? psw : -psw) + (c[1] ? pch : -pch);
    end
  end

  logic                       v5;
  logic signed [34:0]         s5_x [4];
  logic signed [34:0]         s5_y [4];
  logic [31:0]                s5_rgba;
  logic [sqvs_pkg::NUM_W-1:0] s5_tn [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    s5_x    <= x_sum;
    s5_y    <= y_sum;
    s5_rgba <= s4_rgba;
    s5_tn   <= s4_tn;
  end

  // ---------------- stage 6: rounding numerators, offset into quotient range ----------------
  // ndc_x: add 16384 divisors so the quotient lands in [0, 65535].
  // ndc_y: add 16383 divisors; the output is then the inverted quotient.
  logic signed [37:0] ofs_x, ofs_y;

  assign ofs_x = 38'({den_x[sqvs_pkg::DEN_W-1:1]}) + 38'({den_x, 14'd0});
  assign ofs_y = 38'({den_y[sqvs_pkg::DEN_W-1:1]}) + 38'({den_y, 14'd0}) - 38'(den_y);

  logic                       v6;
  logic signed [37:0]         s6_nx [4];
  logic signed [37:0]         s6_ny [4];
  logic [31:0]                s6_rgba;
  logic [sqvs_pkg::NUM_W-1:0] s6_tn [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    for (int c = 0; c < 4; c++) begin
      s6_nx[c] <= (38'(s5_x[c]) <<< 1) + ofs_x;
      s6_ny[c] <= (38'(s5_y[c]) <<< 1) + ofs_y;
    end
    s6_rgba <= s5_rgba;
    s6_tn   <= s5_tn;
  end

  // ---------------- stage 7: saturation clamp into divider range ----------------
  logic                       v7;
  logic [sqvs_pkg::NUM_W-1:0] s7_num [LANES];
  logic [31:0]                s7_rgba;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    for (int c = 0; c < 4; c++) begin
      s7_num[c]     <= clamp_num(s6_nx[c], den_x);
      s7_num[4 + c] <= clamp_num(s6_ny[c], den_y);
      s7_num[8 + c] <= s6_tn[c];
    end
    s7_rgba <= s6_rgba;
  end

  // ---------------- divider lanes ----------------
  // Lanes 0-3: ndc_x per corner, 4-7: ndc_y per corner, 8-11: u0, u1, v0, v1.
  logic [sqvs_pkg::DEN_W-1:0] lane_den [LANES];
  logic [sqvs_pkg::QUO_W-1:0] lane_quo [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    if (l < 4) begin : g_x
      assign lane_den[l] = den_x;
    end else if (l < 8) begin : g_y
      assign lane_den[l] = den_y;
    end else if (l < 10) begin : g_u
      assign lane_den[l] = den_u;
    end else begin : g_v
      assign lane_den[l] = den_v;
    end

    sqvs_div u_div (
      .clk (clk),
      .num (s7_num[l]),
      .den (lane_den[l]),
      .quo (lane_quo[l])
    );
  end

  logic [DIV_STAGES-1:0] div_valid;
  logic [31:0]           rgba_dly [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= '0;
    end else begin
      div_valid <= {div_valid[DIV_STAGES-2:0], v7};
    end
    rgba_dly[0] <= s7_rgba;
    for (int i = 1; i < DIV_STAGES; i++) begin
      rgba_dly[i] <= rgba_dly[i-1];
    end
  end

  // ---------------- vertex sequencer ----------------
  logic                     dv;
  logic signed [15:0]       cur_x [4];
  logic signed [15:0]       cur_y [4];
  logic [15:0]              cur_u [2];
  logic [15:0]              cur_v [2];
  logic [31:0]              cur_rgba;
  logic signed [15:0]       hold_x [4];
  logic signed [15:0]       hold_y [4];
  logic [15:0]              hold_u [2];
  logic [15:0]              hold_v [2];
  logic [31:0]              hold_rgba;
  logic [2:0]               seq_k;
  logic                     seq_act;
  logic [2:0]               k_sel;
  logic [1:0]               corner;

  assign dv = div_valid[DIV_STAGES-1];

  // ndc_y is 32767 minus the quotient: invert the low bits and keep the top one.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cur_x[c] = dv ? {~lane_quo[c][15], lane_quo[c][14:0]} : hold_x[c];
      cur_y[c] = dv ? {lane_quo[4 + c][15], ~lane_quo[4 + c][14:0]} : hold_y[c];
    end
    for (int j = 0; j < 2; j++) begin
      cur_u[j] = dv ? lane_quo[8 + j] : hold_u[j];
      cur_v[j] = dv ? lane_quo[10 + j] : hold_v[j];
    end
    cur_rgba = dv ? rgba_dly[DIV_STAGES-1] : hold_rgba;
    k_sel    = dv ? 3'd0 : seq_k;
    corner   = sqvs_pkg::corner_of(k_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_act      <= 1'b0;
      seq_k        <= 3'd0;
      vertex_valid <= 1'b0;
    end else if (dv) begin
      seq_act      <= 1'b1;
      seq_k        <= 3'd1;
      vertex_valid <= 1'b1;
    end else if (seq_act) begin
      seq_act      <= seq_k != 3'd5;
      seq_k        <= seq_k + 3'd1;
      vertex_valid <= 1'b1;
    end else begin
      vertex_valid <= 1'b0;
    end
    hold_x    <= cur_x;
    hold_y    <= cur_y;
    hold_u    <= cur_u;
    hold_v    <= cur_v;
    hold_rgba <= cur_rgba;
    vertex.ndc_x       <= cur_x[corner];
    vertex.ndc_y       <= cur_y[corner];
    vertex.vertex_rgba <= cur_rgba;
    vertex.tex_u       <= cur_u[corner[0]];
    vertex.tex_v       <= cur_v[corner[1]];
    vertex.last_vertex <= k_sel == 3'd5;
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted request");

  a_last_run: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex.last_vertex |-> $past(vertex_valid, 5))
    else $error("last vertex without five vertices before it");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    $rose(vertex_valid) |-> !vertex.last_vertex)
    else $error("vertex run starts with the last vertex");

  a_seq_overlap: assert property (@(posedge clk) disable iff (rst)
    dv |-> !seq_act || seq_k == 3'd6)
    else $error("new sprite reached the sequencer mid-run");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sqvs_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module sqvs_div (
  input  wire logic                         clk,
  input  wire logic [sqvs_pkg::NUM_W-1:0]   num,
  input  wire logic [sqvs_pkg::DEN_W-1:0]   den,
  output logic      [sqvs_pkg::QUO_W-1:0]   quo
);

  // The numerator is always below den * 2^QUO_W, so QUO_W steps suffice.
  logic [sqvs_pkg::NUM_W-1:0] rem [sqvs_pkg::QUO_W+1];
  logic [sqvs_pkg::QUO_W-1:0] qs  [sqvs_pkg::QUO_W+1];

  assign rem[0] = num;
  assign qs[0]  = '0;

  for (genvar i = 0; i < sqvs_pkg::QUO_W; i++) begin : g_step
    localparam int B = sqvs_pkg::QUO_W - 1 - i;
    logic [sqvs_pkg::NUM_W-1:0] dsh;
    logic                       ge;

    assign dsh = sqvs_pkg::NUM_W'(den) << B;
    assign ge  = rem[i] >= dsh;

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? rem[i] - dsh : rem[i];
      qs[i+1]  <= {qs[i][sqvs_pkg::QUO_W-2:0], ge};
    end
  end

  assign quo = qs[sqvs_pkg::QUO_W];

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for the sprite quad vertex setup: directed and random sprites checked vertex by vertex.
module tb;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  sqvs_pkg::sprite_t sprite;
  logic              vertex_valid;
  sqvs_pkg::vertex_t vertex;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  sprite_quad_vertex_setup u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sprite(sprite),
    .vertex_valid(vertex_valid), .vertex(vertex),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copy of the size registers.
  logic [13:0]       vp_w, vp_h, tx_w, tx_h;
  sqvs_pkg::vertex_t vertex_queue[$];
  int                errors;
  int                cycles;
  bit                idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("sprite_quad_vertex_setup: mismatch");
        $finish;
      end
    end
  end

  // Sine of a Q32 turn phase in Q14, Taylor series to x^11.
  function automatic longint sine_q14(input logic [31:0] ph);
    logic [1:0]  quad;
    logic [63:0] r, x, x2, term;
    longint      s;
    int          k;
    quad = ph[31:30];
    r = {34'd0, ph[29:0]};
    if (quad[0]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    s = (s + 32768) >>> 16;
    return quad[1] ? -s : s;
  endfunction

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic logic [15:0] sat16(input longint v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7fff;
    return v[15:0];
  endfunction

  function automatic logic [15:0] texel_coord(input longint s, input longint t);
    longint v;
    v = (2048 * s + t) / (2 * t);
    return v > 65535 ? 16'hffff : v[15:0];
  endfunction

  task automatic predict_vertices(input sqvs_pkg::sprite_t sp);
    longint            ang, idx, sn, cs, cx, cy, vw, vh, tw, th, tx, ty, bx, by;
    logic [31:0]       ph;
    logic [15:0]       nx[4], ny[4], tu[4], tv[4];
    logic [15:0]       u0, u1, v0, v1;
    sqvs_pkg::vertex_t vx;
    int                c, k;
    ang = longint'(sp.rot_angle) % sqvs_pkg::ANGLE_MOD;
    idx = (ang * sqvs_pkg::SINE_ENTRIES_DEF) / sqvs_pkg::ANGLE_MOD;
    ph = 32'((idx << 32) / sqvs_pkg::SINE_ENTRIES_DEF);
    sn = sine_q14(ph);
    cs = sine_q14(ph + 32'h4000_0000);
    cx = 2 * longint'(sp.dst_left) + longint'(sp.dst_width);
    cy = 2 * longint'(sp.dst_top) + longint'(sp.dst_height);
    vw = vp_w == 0 ? 1 : vp_w;
    vh = vp_h == 0 ? 1 : vp_h;
    tw = tx_w == 0 ? 1 : tx_w;
    th = tx_h == 0 ? 1 : tx_h;
    u0 = texel_coord(sp.src_left, tw);
    u1 = texel_coord(longint'(sp.src_left) + sp.src_width, tw);
    v0 = texel_coord(sp.src_top, th);
    v1 = texel_coord(longint'(sp.src_top) + sp.src_height, th);
    for (c = 0; c < 4; c++) begin
      tx = c[0] ? longint'(sp.dst_width) : -longint'(sp.dst_width);
      ty = c[1] ? longint'(sp.dst_height) : -longint'(sp.dst_height);
      bx = cx * 16384 + cs * tx - sn * ty;
      by = cy * 16384 + sn * tx + cs * ty;
      nx[c] = sat16(floor_div(2 * bx + 16 * vw, 32 * vw) - 16384);
      ny[c] = sat16(16384 - floor_div(2 * by + 16 * vh, 32 * vh));
      tu[c] = c[0] ? u1 : u0;
      tv[c] = c[1] ? v1 : v0;
    end
    for (k = 0; k < 6; k++) begin
      c = sqvs_pkg::corner_of(3'(k));
      vx.ndc_x = nx[c];
      vx.ndc_y = ny[c];
      vx.vertex_rgba = sp.tint_rgba;
      vx.tex_u = tu[c];
      vx.tex_v = tv[c];
      vx.last_vertex = (k == 5);
      vertex_queue = {vertex_queue, vx};
    end
  endtask

  // Check every vertex transfer against the oldest expectation.
  always @(posedge clk) begin
    sqvs_pkg::vertex_t ex;
    if (!rst && vertex_valid) begin
      if (vertex_queue.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, vertex);
        errors++;
      end else begin
        ex = vertex_queue.pop_front();
        if (vertex.ndc_x !== ex.ndc_x)
          $display("%0t: ndc_x exp %h got %h", $time, ex.ndc_x, vertex.ndc_x);
        if (vertex.ndc_y !== ex.ndc_y)
          $display("%0t: ndc_y exp %h got %h", $time, ex.ndc_y, vertex.ndc_y);
        if (vertex.vertex_rgba !== ex.vertex_rgba)
          $display("%0t: vertex_rgba exp %h got %h", $time, ex.vertex_rgba,
                   vertex.vertex_rgba);
        if (vertex.tex_u !== ex.tex_u)
          $display("%0t: tex_u exp %h got %h", $time, ex.tex_u, vertex.tex_u);
        if (vertex.tex_v !== ex.tex_v)
          $display("%0t: tex_v exp %h got %h", $time, ex.tex_v, vertex.tex_v);
        if (vertex.last_vertex !== ex.last_vertex)
          $display("%0t: last_vertex exp %b got %b", $time, ex.last_vertex,
                   vertex.last_vertex);
        if (vertex !== ex) errors++;
      end
    end
  end

  // start stays high after a transfer; whoever idles next drops it.
  task automatic send_sprite(input sqvs_pkg::sprite_t sp);
    int gap, i;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      for (i = 0; i < gap; i++) @(posedge clk);
    end
    start <= 1'b1;
    sprite <= sp;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_vertices(sp);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      sqvs_pkg::REG_VIEWPORT_W: vp_w = val[13:0];
      sqvs_pkg::REG_VIEWPORT_H: vp_h = val[13:0];
      sqvs_pkg::REG_TEXTURE_W:  tx_w = val[13:0];
      sqvs_pkg::REG_TEXTURE_H:  tx_h = val[13:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    int i;
    start <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    for (i = 0; i < 30; i++) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [31:0] a, b, c, d);
    drain();
    write_reg(sqvs_pkg::REG_VIEWPORT_W, a);
    write_reg(sqvs_pkg::REG_VIEWPORT_H, b);
    write_reg(sqvs_pkg::REG_TEXTURE_W, c);
    write_reg(sqvs_pkg::REG_TEXTURE_H, d);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic sqvs_pkg::sprite_t random_sprite();
    sqvs_pkg::sprite_t sp;
    sp.dst_left = 16'($urandom);
    sp.dst_top = 16'($urandom);
    sp.dst_width = 16'($urandom);
    sp.dst_height = 16'($urandom);
    sp.tint_rgba = $urandom;
    sp.rot_angle = 13'($urandom);
    sp.src_left = 16'($urandom);
    sp.src_top = 16'($urandom);
    sp.src_width = 16'($urandom);
    sp.src_height = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      // Mostly on-screen rectangles of moderate size.
      sp.dst_left = 16'($urandom_range(0, 20000)) - 16'sd2000;
      sp.dst_top = 16'($urandom_range(0, 12000)) - 16'sd1000;
      sp.dst_width = 16'($urandom_range(0, 4000));
      sp.dst_height = 16'($urandom_range(0, 4000));
      sp.rot_angle = 13'($urandom_range(0, 5759));
      sp.src_width = 16'($urandom_range(0, 4096));
      sp.src_height = 16'($urandom_range(0, 4096));
      sp.src_left = 16'($urandom_range(0, 4096));
      sp.src_top = 16'($urandom_range(0, 4096));
    end
    return sp;
  endfunction

  task automatic test_directed;
    sqvs_pkg::sprite_t sp;
    int a;
    sp = '0;
    send_sprite(sp);
    sp = '1;
    send_sprite(sp);
    sp.dst_left = 16'sh8000; sp.dst_top = 16'sh8000;
    sp.dst_width = 16'sh7fff; sp.dst_height = 16'sh7fff;
    sp.tint_rgba = 32'h1234_5678; sp.rot_angle = 13'd0;
    sp.src_left = 16'hffff; sp.src_top = 16'hffff;
    sp.src_width = 16'hffff; sp.src_height = 16'hffff;
    send_sprite(sp);
    sp.dst_left = 16'sh7fff; sp.dst_top = 16'sh7fff;
    sp.dst_width = 16'sh8000; sp.dst_height = 16'sh8000;
    sp.rot_angle = 13'd5759;
    send_sprite(sp);
    // Quarter turns, and angles past a full turn that wrap around.
    for (a = 0; a < 8; a++) begin
      sp.dst_left = 16'sd3200; sp.dst_top = 16'sd1600;
      sp.dst_width = 16'sd1600; sp.dst_height = -16'sd800;
      sp.src_left = 16'd160; sp.src_top = 16'd320;
      sp.src_width = 16'd1024; sp.src_height = 16'd512;
      sp.tint_rgba = 32'hff00_80c0;
      sp.rot_angle = 13'(a * 1440 + (a >= 4 ? 1 : 0));
      send_sprite(sp);
    end
    sp.rot_angle = 13'd5760; send_sprite(sp);
    sp.rot_angle = 13'h1fff; send_sprite(sp);
  endtask

  task automatic test_random(input int count);
    int i;
    for (i = 0; i < count; i++) send_sprite(random_sprite());
  endtask

  initial begin
    errors = 0;
    idle_on = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    sprite = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vp_w = 14'd1280; vp_h = 14'd720; tx_w = 14'd256; tx_h = 14'd256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(80);
    set_sizes(0, 0, 0, 0);
    test_directed();
    test_random(40);
    set_sizes(14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff);
    test_random(40);
    set_sizes(32'hffff_e001, 8192, 1, 8192);
    test_random(40);
    set_sizes($urandom_range(1, 8192), $urandom_range(1, 8192),
              $urandom_range(1, 64), $urandom_range(1, 64));
    test_random(40);
    idle_on = 1'b0;
    set_sizes(1920, 1080, 512, 128);
    test_random(30);
    drain();
    if (errors == 0) begin
      $display("sprite_quad_vertex_setup: match");
    end else begin
      $display("sprite_quad_vertex_setup: mismatch");
    end
    $finish;
  end
endmodule
